// ===== design/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never");

// Antecedent implies consequent on the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/vsbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsbp_pkg
// Types and constants shared by the bit packer controller and datapath.
// ----------------------------------------------------------------------------
package vsbp_pkg;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_SCORE = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam int unsigned HELD_W     = 7;
    localparam int unsigned BUF_W      = 15;
    localparam logic [15:0] SIGN_BIT   = 16'h8000;
    localparam logic [15:0] MAG_MASK   = 16'h7FFF;
    localparam logic [3:0]  RAW_MAX    = 4'd8;
    localparam logic [3:0]  GROUP_BITS = 4'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture input transfer
        logic step;   // append one chunk of bits
        logic fin;    // release pending byte as last
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;        // current step is the final one of this item
        logic pend_valid;  // a byte waits in the pending register
        logic out_free;    // output register can take a byte this cycle
    } t_status;

endpackage

// ===== design/vsbp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsbp_ctrl
// Sequencer: accepts one item, steps the datapath, then releases the last byte if one is pending.
// ----------------------------------------------------------------------------
module vsbp_ctrl
    import vsbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   w_can_step;

    // Stepping may push the pending byte out, so it waits for room
    assign w_can_step = !i_status.pend_valid || i_status.out_free;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_STEP;
                end
            end
            ST_STEP: begin
                if (w_can_step) begin
                    o_cmd.step = 1'b1;
                    if (i_status.done) n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== design/vsbp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsbp_datapath
// Bit buffer, score mapper, pending byte and output register.
// ----------------------------------------------------------------------------
module vsbp_datapath
    import vsbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_bits_value,
    input  logic [3:0]  i_bit_count,
    input  logic [15:0] i_prev_score,
    input  logic [15:0] i_cur_score,
    input  logic        i_m_tready,
    output t_status     o_status,
    output logic        o_m_tvalid,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    t_mode              r_mode;
    logic [7:0]         r_val;
    logic [3:0]         r_cnt;
    logic [15:0]        r_u;
    logic [HELD_W-1:0]  r_held, n_held;
    logic [2:0]         r_hc, n_hc;
    logic [7:0]         r_pend_byte;
    logic               r_pend_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_valid;

    logic [15:0]        w_sum, w_fold, w_rest;
    logic [3:0]         w_n, w_total;
    logic [7:0]         w_val, w_mask, w_byte;
    logic [BUF_W-1:0]   w_buf;
    logic               w_emit, w_done, w_out_free;

    // Score sum, sign fold, and the score code shifted right by one 4-bit group
    assign w_sum  = i_prev_score + i_cur_score;
    assign w_fold = ((w_sum & SIGN_BIT) != 16'd0) ? (w_sum ^ MAG_MASK) : w_sum;
    assign w_rest = {4'd0, r_u[15:4]};

    // Select the chunk appended by this step
    always_comb begin
        w_n    = 4'd0;
        w_val  = 8'd0;
        w_done = 1'b1;
        case (r_mode)
            MODE_RAW: begin
                w_n = (r_cnt > RAW_MAX) ? RAW_MAX : r_cnt;
            end
            MODE_SCORE: begin
                w_n    = GROUP_BITS;
                w_val  = {3'd0, (w_rest != 16'd0), r_u[3:0]};
                w_done = (w_rest == 16'd0);
            end
            default: begin
                w_n = 4'd0;
            end
        endcase
        w_mask = 8'hFF >> (RAW_MAX - w_n);
        if (r_mode == MODE_RAW) w_val = r_val & w_mask;
    end

    // Append and extract the oldest byte; flush left-aligns the held bits
    always_comb begin
        w_total = {1'b0, r_hc} + w_n;
        w_buf   = ({8'd0, r_held} << w_n) | {7'd0, w_val};
        w_emit  = 1'b0;
        w_byte  = 8'd0;
        n_hc    = w_total[2:0];
        n_held  = HELD_W'(w_buf) & HELD_W'((8'd1 << w_total[2:0]) - 8'd1);
        if (w_total >= RAW_MAX) begin
            w_emit = 1'b1;
            w_byte = 8'(w_buf >> (w_total - RAW_MAX));
        end
        if (r_mode == MODE_FLUSH) begin
            w_emit = (r_hc != 3'd0);
            w_byte = 8'({1'b0, r_held} << (RAW_MAX - {1'b0, r_hc}));
            n_hc   = 3'd0;
            n_held = '0;
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_status.done       = w_done;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = w_out_free;

    // Item capture and bit buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_hc   <= '0;
        end else if (i_cmd.step) begin
            r_held <= n_held;
            r_hc   <= n_hc;
        end
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_val  <= i_bits_value;
            r_cnt  <= i_bit_count;
            r_u    <= {w_fold[14:0], w_fold[15]};
        end else if (i_cmd.step) begin
            r_u <= w_rest;
        end
    end

    // Pending byte: held back until it is known whether it ends the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && w_emit) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.fin) begin
            r_pend_valid <= 1'b0;
        end
        if (i_cmd.step && w_emit) r_pend_byte <= w_byte;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.step && w_emit && r_pend_valid) || (i_cmd.fin && r_pend_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if ((i_cmd.step && w_emit && r_pend_valid) || (i_cmd.fin && r_pend_valid)) begin
            r_out_byte <= r_pend_byte;
            r_out_last <= i_cmd.fin;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/varlen_score_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varlen_score_bit_packer
// MSB-first bit packer with a 4-bit-group varint coder for score deltas.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transfer: tuser selects raw bits,
//   score delta or flush; tdata carries the operands. Master channel emits
//   packed bytes, earliest bit in bit 7, with tlast on the final byte that
//   a command produces (commands that produce no byte emit nothing).
// Sequence:
//   A command is taken, then steps the bit buffer once per chunk: one
//   step for raw and flush, one step per 5-bit group (1 to 4) for a
//   score, then the final byte is released if one is pending. The
//   sequencer runs this step loop over the single shared bit buffer;
//   tready is high only between items.
// Stall:
//   Bytes pass through a pending register and an output register; while
//   the receiver holds tready low the sequencer pauses before a step that
//   would overwrite a waiting byte. Nothing is lost or repeated.
// Reset:
//   Synchronous, active low; empties the bit buffer and drops tvalid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module varlen_score_bit_packer
    import vsbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] bits_value, [11:8] bit_count, [27:12] prev_score,
    // [43:28] cur_score, [47:44] zero
    input  logic [47:0] i_s_tdata,
    // [1:0] mode
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    t_cmd    w_cmd;
    t_status w_status;

    vsbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vsbp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_mode       (i_s_tuser),
        .i_bits_value (i_s_tdata[7:0]),
        .i_bit_count  (i_s_tdata[11:8]),
        .i_prev_score (i_s_tdata[27:12]),
        .i_cur_score  (i_s_tdata[43:28]),
        .i_m_tready   (i_m_tready),
        .o_status     (w_status),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

    // Between items no byte may be left pending
    `ASSERT_NEVER(a_idle_no_pend, i_clk, i_rst_n, o_s_tready && w_status.pend_valid)
    // A step must not overwrite a byte the output cannot take
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n,
        w_cmd.step && w_status.pend_valid && !w_status.out_free)
    // An accepted item keeps the input closed on the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

// ===== sim/vsbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_byte_checker
// Watches both stream channels of the bit packer, predicts the packed bytes
// of every accepted command and compares them in order with the output.
// ----------------------------------------------------------------------------
module packed_byte_checker
    import vsbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    t_packed_byte byte_q[$];       // bytes still owed by the block
    logic [7:0]   item_bytes[$];   // bytes of the command being predicted
    logic [14:0]  held_bits  = '0;
    logic [2:0]   held_count = '0;
    int           mismatch_count = 0;

    // Append n bits (0..8) to the bit buffer, emit a byte once 8 are held
    task automatic append_bits(input logic [7:0] value, input logic [3:0] n);
        logic [7:0]  mask;
        logic [4:0]  total;
        logic [14:0] merged;
        mask   = (n >= RAW_MAX) ? 8'hFF : 8'((9'd1 << n) - 9'd1);
        total  = 5'(held_count) + 5'(n);
        merged = (held_bits << n) | {7'b0, value & mask};
        if (total >= 5'd8) begin
            item_bytes = {item_bytes, 8'(merged >> (total - 5'd8))};
            total = total - 5'd8;
        end
        held_count = total[2:0];
        held_bits  = merged & ((15'd1 << held_count) - 15'd1);
    endtask

    // Work out every byte one command produces; the final one carries last
    task automatic predict_command(input t_mode mode, input logic [47:0] data);
        logic [3:0]   cnt;
        logic [15:0]  sum;
        logic [15:0]  code;
        logic [3:0]   group;
        t_packed_byte entry;
        item_bytes.delete();
        case (mode)
            MODE_RAW: begin
                cnt = data[11:8];
                if (cnt > RAW_MAX)
                    cnt = RAW_MAX;
                append_bits(data[7:0], cnt);
            end
            MODE_SCORE: begin
                // wrapping sum, sign folded into bit 0
                sum  = data[27:12] + data[43:28];
                code = ((sum & SIGN_BIT) != 0) ? (sum ^ MAG_MASK) : sum;
                code = {code[14:0], code[15]};
                do begin
                    group = code[3:0];
                    code  = code >> 4;
                    append_bits({3'b000, code != 16'd0, group}, GROUP_BITS);
                end while (code != 16'd0);
            end
            MODE_FLUSH: begin
                if (held_count != 3'd0) begin
                    item_bytes = {item_bytes, 8'(held_bits << (4'd8 - held_count))};
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: ;
        endcase
        foreach (item_bytes[k]) begin
            entry.data = item_bytes[k];
            entry.last = (k == item_bytes.size() - 1);
            byte_q = {byte_q, entry};
        end
    endtask

    // Compare output transfers first, then predict the input transfer
    always @(posedge i_clk) begin
        t_packed_byte want;
        if (!i_rst_n) begin
            held_bits  = '0;
            held_count = '0;
            byte_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (byte_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    want = byte_q.pop_front();
                    if (want.data !== i_m_tdata || want.last !== i_m_tlast) begin
                        mismatch_count++;
                        $display("%0t: byte mismatch, expected %02h last %0b, %s %02h last %0b",
                                 $time, want.data, want.last, "actual",
                                 i_m_tdata, i_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_command(t_mode'(i_s_tuser), i_s_tdata);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= byte_q.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bit packer: directed raw, score and flush commands, then
// random commands sent in bursts against a receiver with changing stalls.
// ----------------------------------------------------------------------------
module tb;
    import vsbp_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_AFTER   = 150;   // commands sent before the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_CYCLIC
    } t_ready_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = MODE_NONE;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    int          mismatches;
    int          pending;

    int          n_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [15:0] corner_scores [6] = '{16'h0000, 16'h0001, 16'hFFFF,
                                       16'h7FFF, 16'h8000, 16'h7FFE};

    varlen_score_bit_packer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    packed_byte_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // tdata layout: value, count, prev score, cur score, zero pad
    function automatic logic [47:0] operands(input logic [7:0] value, input logic [3:0] cnt,
                                             input logic [15:0] prev, input logic [15:0] cur);
        return {4'b0000, cur, prev, cnt, value};
    endfunction

    // {cur, prev}: fully random, near-cancelling pairs, or corner values
    function automatic logic [31:0] pick_scores();
        logic [15:0] prev;
        logic [15:0] cur;
        int          kind;
        kind = $urandom_range(0, 9);
        prev = 16'($urandom);
        cur  = 16'($urandom);
        if (kind >= 4 && kind < 8) begin
            cur = 16'(-prev) + 16'($urandom_range(0, 64)) - 16'd32;
        end else if (kind >= 8) begin
            prev = corner_scores[$urandom_range(0, 5)];
            cur  = corner_scores[$urandom_range(0, 5)];
        end
        return {cur, prev};
    endfunction

    // One command transfer; the sender may pause between bursts of random length
    task automatic send_cmd(input t_mode mode, input logic [47:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Receiver: changing patterns, with one long hold after HOLD_AFTER commands to back the block up
    initial begin
        t_ready_style style;
        int           phase_left;
        int           tick;
        logic         hold_done;
        style      = READY_ALWAYS;
        phase_left = 0;
        tick       = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_sent >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (phase_left == 0) begin
                style      = t_ready_style'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            tick++;
            case (style)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom);
                READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= (tick % 3 != 0);
            endcase
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int          counted;
        int          pick;
        logic [7:0]  value;
        logic [3:0]  cnt;
        logic [31:0] scores;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: count extremes, masking, zero and oversized count,
        // score corners and wrapping sums, flush with and without bits
        send_cmd(MODE_RAW,   operands(8'hFF, 4'd1,  16'h0000, 16'h0000));
        send_cmd(MODE_RAW,   operands(8'h00, 4'd8,  16'hFFFF, 16'hFFFF));
        send_cmd(MODE_RAW,   operands(8'hFF, 4'd8,  16'h0000, 16'h0000));
        send_cmd(MODE_RAW,   operands(8'hA5, 4'd0,  16'h1234, 16'h4321));
        send_cmd(MODE_RAW,   operands(8'h5A, 4'd15, 16'h0000, 16'h0000));
        send_cmd(MODE_RAW,   operands(8'hFC, 4'd3,  16'h0000, 16'h0000));
        send_cmd(MODE_FLUSH, operands(8'hFF, 4'd15, 16'hFFFF, 16'hFFFF));
        send_cmd(MODE_FLUSH, operands(8'h00, 4'd0,  16'h0000, 16'h0000));
        send_cmd(MODE_NONE,  operands(8'hFF, 4'd8,  16'h7FFF, 16'h8000));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'h0000, 16'h0000));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'h7FFF, 16'h0000));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'h8000, 16'h0000));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'h7FFF, 16'h0001));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'hFFFF, 16'h0000));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'h8000, 16'hFFFF));
        send_cmd(MODE_SCORE, operands(8'h00, 4'd0,  16'd100,  16'hFF9B));
        send_cmd(MODE_RAW,   operands(8'h7F, 4'd7,  16'h0000, 16'h0000));
        send_cmd(MODE_SCORE, operands(8'hFF, 4'd15, 16'd1234, 16'hE7D2));
        send_cmd(MODE_RAW,   operands(8'h01, 4'd9,  16'h0000, 16'h0000));
        send_cmd(MODE_FLUSH, operands(8'h00, 4'd0,  16'h0000, 16'h0000));

        // random: mostly raw and score commands, some flushes, a little noise
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick   = $urandom_range(0, 99);
            value  = 8'($urandom);
            scores = pick_scores();
            if (pick < 45) begin
                cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
                send_cmd(MODE_RAW, operands(value, cnt, scores[15:0], scores[31:16]));
                counted++;
            end else if (pick < 80) begin
                send_cmd(MODE_SCORE, operands(value, 4'($urandom), scores[15:0], scores[31:16]));
                counted++;
            end else if (pick < 93) begin
                send_cmd(MODE_FLUSH, operands(value, 4'($urandom), scores[15:0], scores[31:16]));
                counted++;
            end else begin
                send_cmd(MODE_NONE, operands(value, 4'($urandom), scores[15:0], scores[31:16]));
                counted++;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow for a command still in flight
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
